// ===== design/sm4_pkg.sv =====
package sm4_pkg;

	localparam int unsigned NUM_ROUNDS = 32;
	localparam int unsigned RK_AW = 5;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;
	localparam logic [1:0] REG_DECRYPT  = 2'd2;

	localparam logic [31:0] FK0 = 32'ha3b1bac6;
	localparam logic [31:0] FK1 = 32'h56aa3350;
	localparam logic [31:0] FK2 = 32'h677d9197;
	localparam logic [31:0] FK3 = 32'hb27022dc;

	typedef logic [31:0] word_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic word_t tau(input word_t a);
		return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
	endfunction

	function automatic word_t rotl(input word_t v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// round constant: byte j is (4i+j)*7 mod 256
	function automatic word_t ck_word(input logic [RK_AW-1:0] i);
		logic [7:0] b0;
		b0 = 8'({i, 2'b00}) * 8'd7;
		return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
	endfunction

endpackage

// ===== design/sm4_round.sv =====
// One round of the shared datapath, data (L) or key schedule (L').
module sm4_round (
	input  logic               key_sched,
	input  sm4_pkg::word_t     x0,
	input  sm4_pkg::word_t     x1,
	input  sm4_pkg::word_t     x2,
	input  sm4_pkg::word_t     x3,
	input  sm4_pkg::word_t     rk,
	output sm4_pkg::word_t     nx
);
	sm4_pkg::word_t b;

	always_comb begin
		b = sm4_pkg::tau(x1 ^ x2 ^ x3 ^ rk);
		if (key_sched) begin
			nx = x0 ^ b ^ sm4_pkg::rotl(b, 13) ^ sm4_pkg::rotl(b, 23);
		end else begin
			nx = x0 ^ b ^ sm4_pkg::rotl(b, 2) ^ sm4_pkg::rotl(b, 10)
				^ sm4_pkg::rotl(b, 18) ^ sm4_pkg::rotl(b, 24);
		end
	end
endmodule

// ===== design/sm4_block_cipher.sv =====
// Channel | Signals                                   | Direction
// cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in (ready out)
// in      | in_valid in_stall block_high block_low    | in (stall out)
// out     | out_valid out_stall result_high result_low| out (stall in)
//
// A block is accepted only in idle, so one block is in the rounds at a time.
// After accept the first round key is fetched, the rounds run, and the words are
// handed off to the output register; the next block is taken only after the
// hand-off, once the state machine is back in idle.
// After reset and after every key write the key expansion runs and fills the
// round key memory; no block or register write is taken meanwhile.
// A stalled result keeps the block in the hand-off; no new block runs behind it.
module sm4_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_KEY  = 2'd1;
	localparam logic [1:0] ST_ENC  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  cnt_q;
	logic [63:0] key_high_q, key_low_q;
	logic        decrypt_q;
	sm4_pkg::word_t x_q [4];
	sm4_pkg::word_t rk_mem [sm4_pkg::NUM_ROUNDS];
	sm4_pkg::word_t rk_rd_q;
	sm4_pkg::word_t rk_use, nx;
	logic [4:0]  rd_addr;
	logic        in_acc, start_enc, out_load;
	logic [63:0] res_high_q, res_low_q;

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_stall  = !(state_q == ST_IDLE) || cfg_valid;
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid || !out_stall);

	// round key read address: round cnt_q+1 is fetched while cnt_q executes
	always_comb begin
		logic [4:0] r;
		r = in_acc ? 5'd0 : 5'(cnt_q + 6'd1);
		rd_addr = decrypt_q ? ~r : r;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_KEY) begin
			rk_mem[cnt_q[4:0]] <= nx;
		end
		rk_rd_q <= rk_mem[rd_addr];
	end

	assign rk_use = (state_q == ST_KEY) ? sm4_pkg::ck_word(cnt_q[4:0]) : rk_rd_q;
	assign start_enc = in_acc;

	sm4_round u_round (
		.key_sched (state_q == ST_KEY),
		.x0 (x_q[0]), .x1 (x_q[1]), .x2 (x_q[2]), .x3 (x_q[3]),
		.rk (rk_use),
		.nx (nx)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_KEY;
			cnt_q      <= '0;
			key_high_q <= '0;
			key_low_q  <= '0;
			decrypt_q  <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							sm4_pkg::REG_KEY_HIGH: begin
								key_high_q <= cfg_data;
								state_q    <= ST_KEY;
								cnt_q      <= '0;
							end
							sm4_pkg::REG_KEY_LOW: begin
								key_low_q <= cfg_data;
								state_q   <= ST_KEY;
								cnt_q     <= '0;
							end
							sm4_pkg::REG_DECRYPT: decrypt_q <= cfg_data[0];
							default: ;
						endcase
					end else if (start_enc) begin
						state_q <= ST_ENC;
						cnt_q   <= 6'd63;
					end
				end
				ST_KEY: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ENC: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: word shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q[0] <= sm4_pkg::FK0;
			x_q[1] <= sm4_pkg::FK1;
			x_q[2] <= sm4_pkg::FK2;
			x_q[3] <= sm4_pkg::FK3;
		end else if (state_q == ST_IDLE && cfg_valid &&
			(cfg_index == sm4_pkg::REG_KEY_HIGH || cfg_index == sm4_pkg::REG_KEY_LOW)) begin
			x_q[0] <= ((cfg_index == sm4_pkg::REG_KEY_HIGH) ? cfg_data[63:32] : key_high_q[63:32])
				^ sm4_pkg::FK0;
			x_q[1] <= ((cfg_index == sm4_pkg::REG_KEY_HIGH) ? cfg_data[31:0] : key_high_q[31:0])
				^ sm4_pkg::FK1;
			x_q[2] <= ((cfg_index == sm4_pkg::REG_KEY_LOW) ? cfg_data[63:32] : key_low_q[63:32])
				^ sm4_pkg::FK2;
			x_q[3] <= ((cfg_index == sm4_pkg::REG_KEY_LOW) ? cfg_data[31:0] : key_low_q[31:0])
				^ sm4_pkg::FK3;
		end else if (start_enc) begin
			x_q[0] <= block_high[63:32];
			x_q[1] <= block_high[31:0];
			x_q[2] <= block_low[63:32];
			x_q[3] <= block_low[31:0];
		end else if (state_q == ST_KEY || (state_q == ST_ENC && cnt_q != 6'd63)) begin
			x_q[0] <= x_q[1];
			x_q[1] <= x_q[2];
			x_q[2] <= x_q[3];
			x_q[3] <= nx;
		end
	end

	// output register: words X35..X32
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_high_q <= {x_q[3], x_q[2]};
			res_low_q  <= {x_q[1], x_q[0]};
		end
	end

	assign result_high = res_high_q;
	assign result_low  = res_low_q;
endmodule
